@@ hdl/bbif_pkg.sv @@
// ----------------------------------------------------------------------------
// bbif_pkg
// Shared types, codes and constants for the backlight blink and idle fade
// block.
// ----------------------------------------------------------------------------
package bbif_pkg;

    // time base and pwm resolution
    localparam int TIME_W = 32;
    localparam int PWM_W  = 16;

    // working width of the shared unit: time values and 32-bit products
    localparam int CW    = (TIME_W > 32) ? TIME_W : 32;
    localparam int CNT_W = $clog2(CW + 1);

    localparam logic [15:0] PWM_MASK   = 16'((17'd1 << PWM_W) - 17'd1);
    localparam logic [15:0] FULL_SCALE = 16'hFFFF;

    // command codes (code 3 is treated as evaluate)
    localparam logic [1:0] CMD_EVAL  = 2'd0;
    localparam logic [1:0] CMD_ACT   = 2'd1;
    localparam logic [1:0] CMD_BLINK = 2'd2;

    // register indexes on the config port
    localparam logic [1:0] REG_NORMAL = 2'd0;
    localparam logic [1:0] REG_IDLE   = 2'd1;
    localparam logic [1:0] REG_FADE   = 2'd2;
    localparam logic [1:0] REG_DIMMED = 2'd3;

    // register reset values
    localparam logic [15:0] RST_NORMAL = 16'd1000;
    localparam logic [31:0] RST_IDLE   = 32'd30000;
    localparam logic [15:0] RST_FADE   = 16'd2000;
    localparam logic [15:0] RST_DIMMED = 16'd0;

    typedef enum logic [1:0] {
        MODE_BLINK  = 2'd0,
        MODE_NORMAL = 2'd1,
        MODE_FADE   = 2'd2,
        MODE_DIMMED = 2'd3
    } mode_t;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } op_t;

    typedef struct packed {
        logic [15:0] normal;
        logic [31:0] idle;
        logic [15:0] fade;
        logic [15:0] dimmed;
    } cfg_t;

    // request to the shared multiply / divide unit
    typedef struct packed {
        logic            start;
        op_t             op;
        logic [CW-1:0]   a;     // multiplier (low 16 bits) or dividend
        logic [15:0]     b;     // multiplicand or divisor
    } md_req_t;

    // response from the shared unit
    typedef struct packed {
        logic            done;
        logic [CW-1:0]   quo;
        logic [31:0]     prod;
    } md_rsp_t;

endpackage

@@ hdl/bbif_cfg.sv @@
// ----------------------------------------------------------------------------
// bbif_cfg
// Configuration register file: decodes writes by index and holds the four
// brightness and timing settings.
// ----------------------------------------------------------------------------
module bbif_cfg
    import bbif_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    output cfg_t        cfg
);

    logic [15:0] normal_reg;
    logic [31:0] idle_reg;
    logic [15:0] fade_reg;
    logic [15:0] dimmed_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_reg <= RST_NORMAL;
            idle_reg   <= RST_IDLE;
            fade_reg   <= RST_FADE;
            dimmed_reg <= RST_DIMMED;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_NORMAL: normal_reg <= cfg_wdata[15:0];
                REG_IDLE:   idle_reg   <= cfg_wdata;
                REG_FADE:   fade_reg   <= cfg_wdata[15:0];
                REG_DIMMED: dimmed_reg <= cfg_wdata[15:0];
                default:    ;
            endcase
        end
    end

    assign cfg.normal = normal_reg;
    assign cfg.idle   = idle_reg;
    assign cfg.fade   = fade_reg;
    assign cfg.dimmed = dimmed_reg;

endmodule

@@ hdl/bbif_muldiv.sv @@
// ----------------------------------------------------------------------------
// bbif_muldiv
// Shared iterative unit: 16-step shift-add multiply or CW-step restoring
// divide, both through one 17-bit add/subtract.
// ----------------------------------------------------------------------------
module bbif_muldiv
    import bbif_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  md_req_t req,
    output md_rsp_t rsp
);

    localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(16);
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(CW);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    op_t              op_reg;
    logic [15:0]      opd_reg;
    logic [15:0]      rem_reg;
    logic [CW-1:0]    quo_reg;

    logic [16:0]      shifted;
    logic [16:0]      add_a;
    logic [16:0]      add_b;
    logic             cin;
    logic [17:0]      sum;
    logic [15:0]      rem_next;
    logic [CW-1:0]    quo_next;

    // shared add/subtract operand selection
    always_comb
    begin
        shifted = {rem_reg, quo_reg[CW-1]};
        if (op_reg == OP_DIV)
        begin
            add_a = shifted;
            add_b = ~{1'b0, opd_reg};
            cin   = 1'b1;
        end
        else
        begin
            add_a = {1'b0, rem_reg};
            add_b = quo_reg[0] ? {1'b0, opd_reg} : 17'd0;
            cin   = 1'b0;
        end
        sum = {1'b0, add_a} + {1'b0, add_b} + {17'd0, cin};
    end

    // one step of the selected operation
    always_comb
    begin
        if (op_reg == OP_DIV)
        begin
            // carry out means the shifted remainder was not below the divisor
            if (sum[17])
            begin
                rem_next = sum[15:0];
                quo_next = {quo_reg[CW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[15:0];
                quo_next = {quo_reg[CW-2:0], 1'b0};
            end
        end
        else
        begin
            rem_next = sum[16:1];
            quo_next = {{(CW-16){1'b0}}, sum[0], quo_reg[15:1]};
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_MUL;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                cnt_reg  <= (req.op == OP_DIV) ? DIV_STEPS : MUL_STEPS;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            opd_reg <= req.b;
            rem_reg <= '0;
            quo_reg <= (req.op == OP_DIV) ? req.a : {{(CW-16){1'b0}}, req.a[15:0]};
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.prod = {rem_reg, quo_reg[15:0]};

`ifndef NO_ASSERTIONS
    // partial remainder stays below the divisor throughout a divide
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && op_reg == OP_DIV) |-> (rem_reg < opd_reg))
        else $error("divide remainder not below divisor");

    // a start always leads into a busy run
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg)
        else $error("start did not begin a run");

    // done is a single pulse at the end of a run
    a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (!busy_reg && $past(busy_reg)))
        else $error("done without a finished run");
`endif

endmodule

@@ hdl/backlight_blink_and_idle_fade.sv @@
// ----------------------------------------------------------------------------
// backlight_blink_and_idle_fade
// Backlight pwm compare generator: blink phase, idle timeout and linear fade
// from millisecond timestamps, sequenced around one shared multiply/divide.
// ----------------------------------------------------------------------------
// Normal and dimmed results come from compares alone; a blink phase waits on
// one divide, and a blink start and a fade step each wait on a multiply then a
// divide, through the shared unit's 16 multiply steps and CW (32) divide steps.
// Throughput: one item at a time; s_tready is high only between items, and a
// stalled result holds the next one in hand-over until the output frees.
// Reset (rst_n low, asynchronous): registers return to their defaults, blink
// and activity times clear, the led level sets and no result is pending.
// ----------------------------------------------------------------------------
module backlight_blink_and_idle_fade
    import bbif_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // now_ms[31:0], blink_count[39:32], blink_interval_ms[55:40]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // pwm_compare[15:0], led_on[16], zero[23:17]
    output logic [1:0]  m_tuser    // mode[1:0]
);

    typedef enum logic [3:0] {
        ST_WAIT_IN,
        ST_MUL_END,
        ST_CHECK,
        ST_BLINK_DIV,
        ST_IDLE_CMP,
        ST_FADE_CMP,
        ST_FADE_MUL,
        ST_FADE_DIV,
        ST_DONE
    } state_t;

    cfg_t    cfg;
    md_rsp_t rsp;

    state_t          state_reg;
    md_req_t         req_reg;
    logic [TIME_W-1:0] now_reg;
    logic [15:0]     intv_reg;
    logic [TIME_W-1:0] blink_end_reg;
    logic [15:0]     blink_int_reg;
    logic [TIME_W-1:0] last_act_reg;
    logic            led_reg;
    logic [CW-1:0]   diff_reg;
    logic [15:0]     res_pwm_reg;
    mode_t           res_mode_reg;
    logic            m_tvalid_reg;
    logic [15:0]     out_pwm_reg;
    logic            out_led_reg;
    mode_t           out_mode_reg;

    logic [TIME_W-1:0] end_sum;
    logic              blink_run;
    logic [15:0]       half_div;
    logic [TIME_W-1:0] elapsed;
    logic [15:0]       remaining;
    logic [15:0]       span;
    logic [15:0]       fade_pwm;

    bbif_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bbif_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_reg),
        .rsp   (rsp)
    );

    // per-state arithmetic
    always_comb
    begin
        end_sum   = now_reg + TIME_W'(rsp.prod);
        blink_run = (blink_end_reg > now_reg) && (blink_int_reg != 16'd0);
        half_div  = (blink_int_reg[15:1] == 15'd0) ? 16'd1 : {1'b0, blink_int_reg[15:1]};
        elapsed   = now_reg - last_act_reg;
        remaining = cfg.fade - diff_reg[15:0];
        span      = (cfg.normal > cfg.dimmed) ? (cfg.normal - cfg.dimmed) : 16'd0;
        fade_pwm  = rsp.quo[15:0] + cfg.dimmed;
    end

    // sequencer, state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_WAIT_IN;
            req_reg       <= '0;
            now_reg       <= '0;
            intv_reg      <= '0;
            blink_end_reg <= '0;
            blink_int_reg <= '0;
            last_act_reg  <= '0;
            led_reg       <= 1'b1;
            diff_reg      <= '0;
            res_pwm_reg   <= '0;
            res_mode_reg  <= MODE_BLINK;
            m_tvalid_reg  <= 1'b0;
            out_pwm_reg   <= '0;
            out_led_reg   <= 1'b0;
            out_mode_reg  <= MODE_BLINK;
        end
        else
        begin
            // output transfer frees the register unless a new result loads it
            if (m_tvalid_reg && m_tready && state_reg != ST_DONE)
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_WAIT_IN:
                begin
                    if (s_tvalid)
                    begin
                        now_reg  <= TIME_W'(s_tdata[31:0]);
                        intv_reg <= s_tdata[55:40];
                        state_reg <= ST_CHECK;
                        case (s_tuser)
                            CMD_ACT:
                            begin
                                last_act_reg <= TIME_W'(s_tdata[31:0]);
                            end
                            CMD_BLINK:
                            begin
                                // blink length = count * interval
                                req_reg.start <= 1'b1;
                                req_reg.op    <= OP_MUL;
                                req_reg.a     <= CW'(s_tdata[39:32]);
                                req_reg.b     <= s_tdata[55:40];
                                state_reg     <= ST_MUL_END;
                            end
                            default: ;
                        endcase
                    end
                end

                ST_MUL_END:
                begin
                    if (rsp.done)
                    begin
                        blink_end_reg <= end_sum;
                        blink_int_reg <= intv_reg;
                        state_reg     <= ST_CHECK;
                    end
                    else
                    begin
                        // start is a one-cycle pulse
                        req_reg.start <= 1'b0;
                    end
                end

                ST_CHECK:
                begin
                    if (blink_run)
                    begin
                        // phase = bit 0 of (end - now) / half interval
                        req_reg.start <= 1'b1;
                        req_reg.op    <= OP_DIV;
                        req_reg.a     <= CW'(blink_end_reg - now_reg);
                        req_reg.b     <= half_div;
                        state_reg     <= ST_BLINK_DIV;
                    end
                    else
                    begin
                        diff_reg  <= CW'(elapsed);
                        state_reg <= ST_IDLE_CMP;
                    end
                end

                ST_BLINK_DIV:
                begin
                    if (rsp.done)
                    begin
                        led_reg      <= rsp.quo[0];
                        res_pwm_reg  <= rsp.quo[0] ? 16'd0 : FULL_SCALE;
                        res_mode_reg <= MODE_BLINK;
                        state_reg    <= ST_DONE;
                    end
                    else
                    begin
                        req_reg.start <= 1'b0;
                    end
                end

                ST_IDLE_CMP:
                begin
                    if (diff_reg < CW'(cfg.idle))
                    begin
                        res_pwm_reg  <= cfg.normal;
                        res_mode_reg <= MODE_NORMAL;
                        state_reg    <= ST_DONE;
                    end
                    else
                    begin
                        diff_reg  <= diff_reg - CW'(cfg.idle);
                        state_reg <= ST_FADE_CMP;
                    end
                end

                ST_FADE_CMP:
                begin
                    if (diff_reg >= CW'(cfg.fade))
                    begin
                        res_pwm_reg  <= cfg.dimmed;
                        res_mode_reg <= MODE_DIMMED;
                        state_reg    <= ST_DONE;
                    end
                    else
                    begin
                        // span * remaining, divided by fade next
                        req_reg.start <= 1'b1;
                        req_reg.op    <= OP_MUL;
                        req_reg.a     <= CW'(remaining);
                        req_reg.b     <= span;
                        state_reg     <= ST_FADE_MUL;
                    end
                end

                ST_FADE_MUL:
                begin
                    if (rsp.done)
                    begin
                        req_reg.start <= 1'b1;
                        req_reg.op    <= OP_DIV;
                        req_reg.a     <= CW'(rsp.prod);
                        req_reg.b     <= cfg.fade;
                        state_reg     <= ST_FADE_DIV;
                    end
                    else
                    begin
                        req_reg.start <= 1'b0;
                    end
                end

                ST_FADE_DIV:
                begin
                    if (rsp.done)
                    begin
                        res_pwm_reg  <= fade_pwm;
                        res_mode_reg <= MODE_FADE;
                        state_reg    <= ST_DONE;
                    end
                    else
                    begin
                        req_reg.start <= 1'b0;
                    end
                end

                ST_DONE:
                begin
                    // hand over once the output register is free
                    if (!m_tvalid_reg || m_tready)
                    begin
                        out_pwm_reg  <= res_pwm_reg & PWM_MASK;
                        out_led_reg  <= led_reg;
                        out_mode_reg <= res_mode_reg;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_WAIT_IN;
                    end
                end

                default:
                begin
                    req_reg.start <= 1'b0;
                    state_reg     <= ST_WAIT_IN;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_WAIT_IN);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_led_reg, out_pwm_reg};
    assign m_tuser  = out_mode_reg;

`ifndef NO_ASSERTIONS
    // a blink result is always full scale or off
    a_blink_level: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && out_mode_reg == MODE_BLINK) |->
        (out_pwm_reg == 16'd0 || out_pwm_reg == (FULL_SCALE & PWM_MASK)))
        else $error("blink result not full scale or off");

    // the shared unit only finishes while the sequencer waits for it
    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> (state_reg == ST_MUL_END || state_reg == ST_BLINK_DIV ||
                      state_reg == ST_FADE_MUL || state_reg == ST_FADE_DIV))
        else $error("unit finished outside a wait state");

    // a new result appears only from the hand-over state
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside hand-over");
`endif

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the backlight blink and idle fade block. A directed
// table covers reset values, field extremes, every command, timestamp wrap,
// blink edge cases and fade boundaries. Random traffic then runs under several
// register settings. Typed directed rows are checked against their typed
// values and every other result against a cycle-free predictor of pwm level,
// led level and mode, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tb
    import bbif_pkg::*;
();

    // unused command code, behaves as evaluate
    localparam logic [1:0] CMD_SPARE = 2'd3;

    // receiver stall styles
    localparam int READY_ALWAYS = 0;
    localparam int READY_RANDOM = 1;
    localparam int READY_BURSTY = 2;

    localparam int N_DIRECTED     = 22;
    localparam int N_FIXED_CFG    = 6;
    localparam int N_PHASES       = 8;
    localparam int RAND_PER_PHASE = 156;
    localparam int SETTLE_CYCLES  = 80;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [15:0] pwm;
        logic        led;
        mode_t       mode;
    } light_res_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] now;
        logic [7:0]  count;
        logic [15:0] iv;
        logic        typed;
        logic [15:0] exp_pwm;
        logic        exp_led;
        mode_t       exp_mode;
    } stim_row_t;

    typedef struct packed {
        logic [15:0] normal;
        logic [31:0] idle;
        logic [15:0] fade;
        logic [15:0] dimmed;
    } cfg_set_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_addr  = REG_NORMAL;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata   = '0;   // now_ms[31:0], blink_count[39:32], blink_interval_ms[55:40]
    logic [1:0]  s_tuser   = CMD_EVAL;   // cmd[1:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;          // pwm_compare[15:0], led_on[16], zero[23:17]
    logic [1:0]  m_tuser;          // mode[1:0]

    // predictor copy of registers and state
    logic [15:0] cfg_normal = RST_NORMAL;
    logic [31:0] cfg_idle   = RST_IDLE;
    logic [15:0] cfg_fade   = RST_FADE;
    logic [15:0] cfg_dimmed = RST_DIMMED;
    logic [31:0] blink_end_ms = '0;
    logic [15:0] blink_iv     = '0;
    logic [31:0] act_ms       = '0;
    logic        led_lvl      = 1'b1;

    light_res_t pending_lights [$];
    int         mismatch_cnt = 0;
    int         burst_left   = 0;
    logic [31:0] ms_clock    = '0;

    // directed items, expected values typed in only where obvious
    stim_row_t dir_rows [N_DIRECTED] = '{
        // reset state, both time extremes
        '{CMD_EVAL,  32'd0,          8'd0,   16'd0,      1'b1, 16'd1000,   1'b1, MODE_NORMAL},
        '{CMD_EVAL,  32'hFFFF_FFFF,  8'd0,   16'd0,      1'b1, 16'd0,      1'b1, MODE_DIMMED},
        // unused command only evaluates
        '{CMD_SPARE, 32'd29999,      8'hFF,  16'hFFFF,   1'b1, 16'd1000,   1'b1, MODE_NORMAL},
        // fade boundaries
        '{CMD_EVAL,  32'd30000,      8'd0,   16'd0,      1'b1, 16'd1000,   1'b1, MODE_FADE},
        '{CMD_EVAL,  32'd31999,      8'd0,   16'd0,      1'b1, 16'd0,      1'b1, MODE_FADE},
        '{CMD_EVAL,  32'd32000,      8'd0,   16'd0,      1'b1, 16'd0,      1'b1, MODE_DIMMED},
        // activity at the top of time, elapsed wraps
        '{CMD_ACT,   32'hFFFF_FFFF,  8'hFF,  16'hFFFF,   1'b1, 16'd1000,   1'b1, MODE_NORMAL},
        '{CMD_EVAL,  32'd5,          8'd0,   16'd0,      1'b0, 16'd0,      1'b0, MODE_BLINK},
        '{CMD_EVAL,  32'd30998,      8'd0,   16'd0,      1'b0, 16'd0,      1'b0, MODE_BLINK},
        // plain blink and its phases
        '{CMD_BLINK, 32'd1000,       8'd4,   16'd100,    1'b1, 16'hFFFF,   1'b0, MODE_BLINK},
        '{CMD_EVAL,  32'd1050,       8'd0,   16'd0,      1'b0, 16'd0,      1'b0, MODE_BLINK},
        '{CMD_EVAL,  32'd1399,       8'd0,   16'd0,      1'b0, 16'd0,      1'b0, MODE_BLINK},
        '{CMD_EVAL,  32'd1400,       8'd0,   16'd0,      1'b0, 16'd0,      1'b0, MODE_BLINK},
        // zero count, wrapped end time, largest blink
        '{CMD_BLINK, 32'd2000,       8'd0,   16'd100,    1'b0, 16'd0,      1'b0, MODE_BLINK},
        '{CMD_BLINK, 32'hFFFF_FFF0,  8'hFF,  16'hFFFF,   1'b0, 16'd0,      1'b0, MODE_BLINK},
        '{CMD_BLINK, 32'd0,          8'hFF,  16'hFFFF,   1'b0, 16'd0,      1'b0, MODE_BLINK},
        // interval of one gives half interval zero, interval zero is no blink
        '{CMD_BLINK, 32'd100,        8'd5,   16'd1,      1'b0, 16'd0,      1'b0, MODE_BLINK},
        '{CMD_BLINK, 32'd200,        8'd3,   16'd0,      1'b0, 16'd0,      1'b0, MODE_BLINK},
        '{CMD_BLINK, 32'd300,        8'd1,   16'd2,      1'b0, 16'd0,      1'b0, MODE_BLINK},
        '{CMD_EVAL,  32'd301,        8'd0,   16'd0,      1'b0, 16'd0,      1'b0, MODE_BLINK},
        '{CMD_ACT,   32'd400,        8'd0,   16'd0,      1'b0, 16'd0,      1'b0, MODE_BLINK},
        '{CMD_SPARE, 32'h8000_0000,  8'd0,   16'd0,      1'b0, 16'd0,      1'b0, MODE_BLINK}
    };

    // register settings: defaults, extremes, normal below dimmed, zero fade
    cfg_set_t cfg_plan [N_FIXED_CFG] = '{
        '{16'd1000,  32'd30000,       16'd2000,  16'd0},
        '{16'hFFFF,  32'd0,           16'd1,     16'hFFFF},
        '{16'd100,   32'd50,          16'd300,   16'd5000},
        '{16'hFFFF,  32'hFFFF_FFFF,   16'hFFFF,  16'd0},
        '{16'd0,     32'd10,          16'd0,     16'hFFFF},
        '{16'd40000, 32'd500,         16'd700,   16'd123}
    };

    backlight_blink_and_idle_fade uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #8_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // expected light output for one item, updates predictor state
    function automatic light_res_t predict_backlight(input logic [1:0] cmd,
                                                      input logic [31:0] now,
                                                      input logic [7:0] count,
                                                      input logic [15:0] iv);
        light_res_t  r;
        logic [31:0] since;
        logic [63:0] half;
        logic [63:0] span;
        logic [63:0] remain;
        logic [63:0] level;
        if (cmd == CMD_ACT)
            act_ms = now;
        else if (cmd == CMD_BLINK)
        begin
            blink_end_ms = now + count * iv;
            blink_iv     = iv;
        end
        if (blink_end_ms > now && blink_iv != 16'd0)
        begin
            // phase bit counts half intervals left to the end
            half = 64'(blink_iv >> 1);
            if (half == 64'd0)
                half = 64'd1;
            since   = blink_end_ms - now;
            level   = 64'(since) / half;
            led_lvl = level[0];
            r.pwm   = level[0] ? 16'd0 : FULL_SCALE;
            r.mode  = MODE_BLINK;
        end
        else
        begin
            since = now - act_ms;
            if (since < cfg_idle)
            begin
                r.pwm  = cfg_normal;
                r.mode = MODE_NORMAL;
            end
            else if (since - cfg_idle >= cfg_fade)
            begin
                r.pwm  = cfg_dimmed;
                r.mode = MODE_DIMMED;
            end
            else
            begin
                // linear fade, level saturates at dimmed
                remain = 64'(cfg_fade) - 64'(since - cfg_idle);
                span   = (cfg_normal > cfg_dimmed) ? 64'(cfg_normal - cfg_dimmed) : 64'd0;
                level  = span * remain / 64'(cfg_fade) + 64'(cfg_dimmed);
                r.pwm  = level[15:0];
                r.mode = MODE_FADE;
            end
        end
        r.led = led_lvl;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
            $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    endtask

    // one input transfer, then the sender's burst and gap pacing
    task automatic send_light(input logic [1:0] cmd, input logic [31:0] now,
                              input logic [7:0] count, input logic [15:0] iv,
                              input logic typed, input light_res_t typed_res);
        light_res_t p;
        int         gap;
        s_tuser  <= cmd;
        s_tdata  <= {iv, count, now};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        p = predict_backlight(cmd, now, count, iv);
        pending_lights.push_back(typed ? typed_res : p);
        ms_clock = now;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
        end
    endtask

    // hold the sender until every expected result has come out
    task automatic quiesce();
        if (s_tvalid)
            s_tvalid <= 1'b0;
        while (pending_lights.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all four registers back to back
    task automatic program_regs(input cfg_set_t c);
        logic [1:0]  addrs [4];
        logic [31:0] vals  [4];
        addrs = '{REG_NORMAL, REG_IDLE, REG_FADE, REG_DIMMED};
        vals  = '{{16'd0, c.normal}, c.idle, {16'd0, c.fade}, {16'd0, c.dimmed}};
        for (int k = 0; k < 4; k++)
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= addrs[k];
            cfg_wdata <= vals[k];
            @(posedge clk);
        end
        cfg_we     <= 1'b0;
        cfg_normal = c.normal;
        cfg_idle   = c.idle;
        cfg_fade   = c.fade;
        cfg_dimmed = c.dimmed;
    endtask

    // receiver stalls: always ready, random, or long on/off bursts
    initial
    begin
        int   style;
        int   span_cycles;
        int   hold;
        logic cur;
        hold = 0;
        cur  = 1'b1;
        forever
        begin
            style       = $urandom_range(READY_ALWAYS, READY_BURSTY);
            span_cycles = $urandom_range(32, 200);
            repeat (span_cycles)
            begin
                @(posedge clk);
                case (style)
                    READY_ALWAYS: m_tready <= 1'b1;
                    READY_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
                    default:
                    begin
                        if (hold == 0)
                        begin
                            cur  = ~cur;
                            hold = cur ? $urandom_range(1, 5) : $urandom_range(1, 12);
                        end
                        hold--;
                        m_tready <= cur;
                    end
                endcase
            end
        end
    end

    // result checker, one output transfer per edge at most
    always @(posedge clk)
    begin
        light_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_lights.size() == 0)
                flag_mismatch("result with none pending", '0, {6'd0, m_tuser, m_tdata});
            else
            begin
                want = pending_lights.pop_front();
                if (m_tdata[15:0] !== want.pwm)
                    flag_mismatch("pwm_compare", 32'(want.pwm), 32'(m_tdata[15:0]));
                if (m_tdata[16] !== want.led)
                    flag_mismatch("led_on", 32'(want.led), 32'(m_tdata[16]));
                if (m_tuser !== want.mode)
                    flag_mismatch("mode", 32'(want.mode), 32'(m_tuser));
            end
        end
    end

    // stimulus
    initial
    begin
        int          drain_at;
        int          sel;
        logic [1:0]  cmd;
        logic [31:0] now;
        logic [7:0]  cnt;
        logic [15:0] iv;
        cfg_set_t    cs;
        light_res_t  typed_res;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            typed_res = '{dir_rows[i].exp_pwm, dir_rows[i].exp_led, dir_rows[i].exp_mode};
            send_light(dir_rows[i].cmd, dir_rows[i].now, dir_rows[i].count,
                       dir_rows[i].iv, dir_rows[i].typed, typed_res);
        end

        // random phases, each under its own register setting
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph < N_FIXED_CFG)
                cs = cfg_plan[ph];
            else
            begin
                cs.normal = 16'($urandom_range(0, 16'hFFFF));
                cs.idle   = $urandom_range(0, 5000);
                cs.fade   = 16'($urandom_range(0, 3000));
                cs.dimmed = 16'($urandom_range(0, 16'hFFFF));
            end
            quiesce();
            program_regs(cs);
            drain_at = $urandom_range(10, RAND_PER_PHASE - 10);
            for (int i = 0; i < RAND_PER_PHASE; i++)
            begin
                if (i == drain_at)
                    quiesce();
                sel = $urandom_range(0, 99);
                if (sel < 62)
                    cmd = CMD_EVAL;
                else if (sel < 77)
                    cmd = CMD_ACT;
                else if (sel < 94)
                    cmd = CMD_BLINK;
                else
                    cmd = CMD_SPARE;
                cnt = 8'(($urandom_range(0, 6) != 0) ? $urandom_range(0, 12)
                                                     : $urandom_range(0, 255));
                iv  = 16'(($urandom_range(0, 4) != 0) ? $urandom_range(0, 300)
                                                      : $urandom_range(0, 16'hFFFF));
                // time mostly runs forward, often aimed at the fade or a blink
                sel = $urandom_range(0, 99);
                if (sel < 55)
                    now = ms_clock + $urandom_range(0, 64);
                else if (sel < 70)
                    now = act_ms + cfg_idle - 32'd3 + $urandom_range(0, cfg_fade + 6);
                else if (sel < 82)
                    now = blink_end_ms - $urandom_range(0, 2 * blink_iv + 8);
                else if (sel < 92)
                    now = ms_clock + $urandom_range(0, 20000);
                else
                    now = $urandom;
                send_light(cmd, now, cnt, iv, 1'b0, '0);
            end
        end

        quiesce();
        if (mismatch_cnt == 0 && pending_lights.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
